// ===== rtl/core/grsm_pkg.sv =====
// ----------------------------------------------------------------------------
// grsm_pkg
// Shared widths, state encoding, control structs and the full-scale table
// for the gyro rate scaling and running mean unit.
// ----------------------------------------------------------------------------
package grsm_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int AXES        = 3;
  localparam int AXIS_W      = $clog2(AXES);
  localparam int RAW_W       = 16;
  localparam int FS_W        = 12;
  localparam int FSSEL_W     = 2;
  localparam int PROD_W      = RAW_W + FS_W - 1;
  localparam int SCALE_SHIFT = 15;
  localparam int SUM_W       = PROD_W + COUNT_BITS + 1;
  localparam int OUT_W       = 12;
  // The mean never exceeds 2000 in magnitude, so 11 quotient bits suffice.
  localparam int QUO_W       = 11;
  localparam int DIVD_W      = SUM_W - SCALE_SHIFT;
  localparam int STEP_W      = $clog2(QUO_W);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [AXIS_W-1:0]     LAST_AXIS = AXIS_W'(AXES - 1);
  localparam logic [STEP_W-1:0]     LAST_STEP = STEP_W'(QUO_W - 1);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_MUL       = 7'b0000010,
    ST_ACC       = 7'b0000100,
    ST_DIV_LOAD  = 7'b0001000,
    ST_DIV_STEP  = 7'b0010000,
    ST_DIV_STORE = 7'b0100000,
    ST_OUT       = 7'b1000000
  } state_t;

  typedef struct packed {
    logic              capture;
    logic              mult;
    logic              accum;
    logic              div_load;
    logic              div_step;
    logic              div_store;
    logic              out_load;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic out_busy;
  } stat_t;

  function automatic logic [FS_W-1:0] full_scale(input logic [FSSEL_W-1:0] sel);
    logic [FS_W-1:0] fs;
    case (sel)
      2'd0:    fs = FS_W'(250);
      2'd1:    fs = FS_W'(500);
      2'd2:    fs = FS_W'(1000);
      2'd3:    fs = FS_W'(2000);
      default: fs = FS_W'(250);
    endcase
    return fs;
  endfunction

endpackage

// ===== rtl/core/gyro_rate_scale_and_running_mean_unit.sv =====
// ----------------------------------------------------------------------------
// gyro_rate_scale_and_running_mean_unit
// Scales raw three-axis gyro samples to degrees per second and keeps a
// running mean per axis since the last clear.
//
// Each item is a raw sample or a clear command and yields exactly one result
// item. A sample passes through the single shared restoring divider, which
// runs 11 steps for each of the three axis means, and its result is loaded
// once the output register is free; a clear skips the divider and the
// divisions. The next item is accepted in the cycle after the result is loaded,
// while that result may still wait in the output register. Rates and means are
// truncated toward zero; once the sample count saturates, samples no longer
// accumulate and count_full is set. full_scale_select is written through
// cfg_we/cfg_wdata and is sampled when an item is accepted.
// ----------------------------------------------------------------------------
module gyro_rate_scale_and_running_mean_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [grsm_pkg::FSSEL_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic signed [grsm_pkg::RAW_W-1:0] raw_x,
  input  logic signed [grsm_pkg::RAW_W-1:0] raw_y,
  input  logic signed [grsm_pkg::RAW_W-1:0] raw_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [grsm_pkg::OUT_W-1:0] rate_x,
  output logic signed [grsm_pkg::OUT_W-1:0] rate_y,
  output logic signed [grsm_pkg::OUT_W-1:0] rate_z,
  output logic signed [grsm_pkg::OUT_W-1:0] mean_x,
  output logic signed [grsm_pkg::OUT_W-1:0] mean_y,
  output logic signed [grsm_pkg::OUT_W-1:0] mean_z,
  output logic                              count_full
);
  import grsm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  grsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  grsm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .kind       (kind),
    .raw_x      (raw_x),
    .raw_y      (raw_y),
    .raw_z      (raw_z),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rate_x     (rate_x),
    .rate_y     (rate_y),
    .rate_z     (rate_z),
    .mean_x     (mean_x),
    .mean_y     (mean_y),
    .mean_z     (mean_z),
    .count_full (count_full)
  );

  // Only one item is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in flight");

  // A result is only loaded while the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result loaded over a waiting result");

  // The divider must keep the x and z means within the widest full-scale range.
  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(mean_x) <= 2000) && ($signed(mean_x) >= -2000) &&
                  ($signed(mean_z) <= 2000) && ($signed(mean_z) >= -2000))
    else $error("mean out of range");

endmodule

// ===== rtl/core/grsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// grsm_ctrl
// Sequencer: capture, multiply, accumulate, three divisions (skipped for a clear), result load.
// ----------------------------------------------------------------------------
module grsm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  grsm_pkg::stat_t stat,
  output grsm_pkg::cmd_t  cmd
);
  import grsm_pkg::*;

  state_t            state, state_next;
  logic [AXIS_W-1:0] axis, axis_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      step  <= step_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    axis_next  = axis;
    step_next  = step;
    cmd        = '0;
    cmd.axis   = axis;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mult   = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.accum  = 1'b1;
        axis_next  = '0;
        state_next = stat.is_clear ? ST_OUT : ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        step_next    = '0;
        state_next   = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == LAST_STEP) begin
          state_next = ST_DIV_STORE;
        end
      end
      ST_DIV_STORE: begin
        cmd.div_store = 1'b1;
        if (axis == LAST_AXIS) begin
          state_next = ST_OUT;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = ST_DIV_LOAD;
        end
      end
      ST_OUT: begin
        // Hold until the previous result has left the output register.
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/grsm_dp.sv =====
// ----------------------------------------------------------------------------
// grsm_dp
// Datapath: full-scale register, products, accumulators, sample count,
// shared restoring divider for the means, and the output register.
// ----------------------------------------------------------------------------
module grsm_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [grsm_pkg::FSSEL_W-1:0]      cfg_wdata,
  input  logic                              kind,
  input  logic signed [grsm_pkg::RAW_W-1:0] raw_x,
  input  logic signed [grsm_pkg::RAW_W-1:0] raw_y,
  input  logic signed [grsm_pkg::RAW_W-1:0] raw_z,
  input  grsm_pkg::cmd_t                    cmd,
  output grsm_pkg::stat_t                   stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [grsm_pkg::OUT_W-1:0] rate_x,
  output logic signed [grsm_pkg::OUT_W-1:0] rate_y,
  output logic signed [grsm_pkg::OUT_W-1:0] rate_z,
  output logic signed [grsm_pkg::OUT_W-1:0] mean_x,
  output logic signed [grsm_pkg::OUT_W-1:0] mean_y,
  output logic signed [grsm_pkg::OUT_W-1:0] mean_z,
  output logic                              count_full
);
  import grsm_pkg::*;

  logic [FSSEL_W-1:0]      fs_sel;
  logic [FS_W-1:0]         fs;
  logic                    kind_r;
  logic signed [RAW_W-1:0] raw      [AXES];
  logic signed [PROD_W-1:0] prod    [AXES];
  logic signed [SUM_W-1:0] axis_sum [AXES];
  logic [COUNT_BITS-1:0]   sample_count;
  logic                    full;
  logic signed [OUT_W-1:0] rate     [AXES];
  logic signed [OUT_W-1:0] mean     [AXES];

  logic [COUNT_BITS-1:0]   rem;
  logic [QUO_W-1:0]        quo;
  logic                    neg;

  logic signed [PROD_W:0]  mul_res  [AXES];
  logic signed [OUT_W-1:0] rate_val [AXES];
  logic [COUNT_BITS-1:0]   count_next;
  logic                    take;
  logic [SUM_W-1:0]        sum_mag;
  logic [DIVD_W-1:0]       divd;
  logic [COUNT_BITS:0]     trial;
  logic [COUNT_BITS:0]     diff;

  assign stat.is_clear = kind_r;
  assign stat.out_busy = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fs_sel <= '0;
    end else if (cfg_we) begin
      fs_sel <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind;
      fs     <= full_scale(fs_sel);
      raw[0] <= raw_x;
      raw[1] <= raw_y;
      raw[2] <= raw_z;
    end
  end

  // Products and truncated rates, one per axis.
  always_comb begin
    logic [PROD_W-1:0] mag;
    logic [OUT_W-1:0]  r;
    for (int i = 0; i < AXES; i++) begin
      mul_res[i] = (PROD_W + 1)'(raw[i]) * $signed({{(PROD_W + 1 - FS_W){1'b0}}, fs});
      mag = prod[i][PROD_W-1] ? PROD_W'(-prod[i]) : PROD_W'(prod[i]);
      r   = OUT_W'(mag >> SCALE_SHIFT);
      rate_val[i] = prod[i][PROD_W-1] ? $signed(-r) : $signed(r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      for (int i = 0; i < AXES; i++) begin
        prod[i] <= mul_res[i][PROD_W-1:0];
      end
    end
  end

  assign take       = (sample_count != COUNT_MAX);
  assign count_next = take ? sample_count + 1'b1 : sample_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      for (int i = 0; i < AXES; i++) begin
        axis_sum[i] <= '0;
      end
    end else if (cmd.accum) begin
      if (kind_r == KIND_CLEAR) begin
        sample_count <= '0;
        for (int i = 0; i < AXES; i++) begin
          axis_sum[i] <= '0;
        end
      end else begin
        sample_count <= count_next;
        if (take) begin
          for (int i = 0; i < AXES; i++) begin
            axis_sum[i] <= axis_sum[i] + SUM_W'(prod[i]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      full <= (count_next == COUNT_MAX);
      for (int i = 0; i < AXES; i++) begin
        rate[i] <= rate_val[i];
      end
    end
  end

  // Mean magnitude is floor(floor(|sum| / 32768) / count). The upper
  // dividend bits are already below the count, so they seed the remainder.
  assign sum_mag = axis_sum[cmd.axis][SUM_W-1] ? SUM_W'(-axis_sum[cmd.axis])
                                               : SUM_W'(axis_sum[cmd.axis]);
  assign divd    = DIVD_W'(sum_mag >> SCALE_SHIFT);
  assign trial   = {rem, quo[QUO_W-1]};
  assign diff    = trial - {1'b0, sample_count};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= COUNT_BITS'(divd >> QUO_W);
      quo <= divd[QUO_W-1:0];
      neg <= axis_sum[cmd.axis][SUM_W-1];
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, sample_count}) begin
        rem <= diff[COUNT_BITS-1:0];
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= trial[COUNT_BITS-1:0];
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      mean[cmd.axis] <= neg ? $signed(-OUT_W'(quo)) : $signed(OUT_W'(quo));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (kind_r == KIND_CLEAR) begin
        rate_x     <= '0;
        rate_y     <= '0;
        rate_z     <= '0;
        mean_x     <= '0;
        mean_y     <= '0;
        mean_z     <= '0;
        count_full <= 1'b0;
      end else begin
        rate_x     <= rate[0];
        rate_y     <= rate[1];
        rate_z     <= rate[2];
        mean_x     <= mean[0];
        mean_y     <= mean[1];
        mean_z     <= mean[2];
        count_full <= full;
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw gyro samples and clear commands into the rate scaling and running
// mean unit, predicts each result item from a behavioral model of the scaling
// and the per-axis averaging or from the directed table, and compares each
// result field by field. A short directed table covers the extremes of the raw
// fields and every full-scale setting. Random phases with stalls on both channels
// follow; the closing run drives large samples at the widest full scale, idle-free.
// ----------------------------------------------------------------------------
module testbench;
  import grsm_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SCALE_DIV    = 32768;
  localparam int PHASE_ITEMS  = 300;
  localparam int PHASES       = 5;
  localparam int FINAL_ITEMS  = 240;
  localparam int TAIL_ITEMS   = 20;

  localparam logic [FSSEL_W-1:0] FS_SEL_250  = 2'd0;
  localparam logic [FSSEL_W-1:0] FS_SEL_500  = 2'd1;
  localparam logic [FSSEL_W-1:0] FS_SEL_1000 = 2'd2;
  localparam logic [FSSEL_W-1:0] FS_SEL_2000 = 2'd3;

  typedef enum logic {
    OP_ITEM,
    OP_CFG
  } plan_op_e;

  typedef struct packed {
    logic signed [OUT_W-1:0] rate_x;
    logic signed [OUT_W-1:0] rate_y;
    logic signed [OUT_W-1:0] rate_z;
    logic signed [OUT_W-1:0] mean_x;
    logic signed [OUT_W-1:0] mean_y;
    logic signed [OUT_W-1:0] mean_z;
    logic                    count_full;
  } gyro_result_t;

  typedef struct packed {
    plan_op_e          op;
    logic              kind;
    logic [RAW_W-1:0]  x;
    logic [RAW_W-1:0]  y;
    logic [RAW_W-1:0]  z;
    logic [FSSEL_W-1:0] fs_sel;
    logic              typed;
    gyro_result_t      res;
  } plan_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [FSSEL_W-1:0]        cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      kind = KIND_SAMPLE;
  logic signed [RAW_W-1:0]   raw_x = '0;
  logic signed [RAW_W-1:0]   raw_y = '0;
  logic signed [RAW_W-1:0]   raw_z = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b1;
  logic signed [OUT_W-1:0]   rate_x;
  logic signed [OUT_W-1:0]   rate_y;
  logic signed [OUT_W-1:0]   rate_z;
  logic signed [OUT_W-1:0]   mean_x;
  logic signed [OUT_W-1:0]   mean_y;
  logic signed [OUT_W-1:0]   mean_z;
  logic                      count_full;

  // Travels with the payload: a result typed into the directed table.
  logic                      in_typed = 1'b0;
  gyro_result_t              in_typed_res = '0;

  longint                    sum_track [AXES];
  logic [COUNT_BITS-1:0]     count_track = '0;
  logic [FSSEL_W-1:0]        fs_sel_track = FS_SEL_250;
  gyro_result_t              results_due [$];
  plan_row_t                 stim_plan [$];
  int                        fail_count = 0;
  int                        stall_pct = 0;
  int                        stall_left = 0;
  int                        cycle_count = 0;

  gyro_rate_scale_and_running_mean_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .raw_x      (raw_x),
    .raw_y      (raw_y),
    .raw_z      (raw_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rate_x     (rate_x),
    .rate_y     (rate_y),
    .rate_z     (rate_z),
    .mean_x     (mean_x),
    .mean_y     (mean_y),
    .mean_z     (mean_z),
    .count_full (count_full)
  );

  always #5 clk = ~clk;

  // Scales one sample, folds it into the running sums and returns the result
  // item; a clear empties the sums and the count.
  function automatic gyro_result_t scale_and_average(input logic k,
                                                     input logic signed [RAW_W-1:0] x,
                                                     input logic signed [RAW_W-1:0] y,
                                                     input logic signed [RAW_W-1:0] z);
    longint       raw_v [AXES];
    longint       fs;
    longint       prod;
    longint       mean;
    bit           accept;
    logic [OUT_W-1:0] rate_f [AXES];
    logic [OUT_W-1:0] mean_f [AXES];
    gyro_result_t r;
    r = '0;
    if (k == KIND_CLEAR) begin
      for (int i = 0; i < AXES; i++) sum_track[i] = 0;
      count_track = '0;
      return r;
    end
    case (fs_sel_track)
      FS_SEL_250:  fs = 250;
      FS_SEL_500:  fs = 500;
      FS_SEL_1000: fs = 1000;
      default:     fs = 2000;
    endcase
    raw_v[0] = longint'(x);
    raw_v[1] = longint'(y);
    raw_v[2] = longint'(z);
    accept = (count_track != COUNT_MAX);
    if (accept) count_track = count_track + 1'b1;
    for (int i = 0; i < AXES; i++) begin
      prod = raw_v[i] * fs;
      if (accept) sum_track[i] = sum_track[i] + prod;
      mean = 0;
      if (count_track != 0)
        mean = sum_track[i] / (longint'(count_track) * SCALE_DIV);
      rate_f[i] = OUT_W'(prod / SCALE_DIV);
      mean_f[i] = OUT_W'(mean);
    end
    r.rate_x = rate_f[0];
    r.rate_y = rate_f[1];
    r.rate_z = rate_f[2];
    r.mean_x = mean_f[0];
    r.mean_y = mean_f[1];
    r.mean_z = mean_f[2];
    r.count_full = (count_track == COUNT_MAX);
    return r;
  endfunction

  function automatic gyro_result_t make_res(input int rx, input int ry, input int rz,
                                            input int mx, input int my, input int mz,
                                            input logic full);
    gyro_result_t r;
    r.rate_x = OUT_W'(rx);
    r.rate_y = OUT_W'(ry);
    r.rate_z = OUT_W'(rz);
    r.mean_x = OUT_W'(mx);
    r.mean_y = OUT_W'(my);
    r.mean_z = OUT_W'(mz);
    r.count_full = full;
    return r;
  endfunction

  function automatic logic [RAW_W-1:0] rand_raw();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return '0;
      3:       return RAW_W'(int'($urandom_range(64)) - 32);
      default: return RAW_W'($urandom());
    endcase
  endfunction

  task automatic plan_row(input plan_op_e op, input logic k, input logic [RAW_W-1:0] x,
                          input logic [RAW_W-1:0] y, input logic [RAW_W-1:0] z,
                          input logic [FSSEL_W-1:0] sel, input logic typed,
                          input gyro_result_t res);
    plan_row_t row;
    row.op = op;
    row.kind = k;
    row.x = x;
    row.y = y;
    row.z = z;
    row.fs_sel = sel;
    row.typed = typed;
    row.res = res;
    stim_plan.push_back(row);
  endtask

  task automatic send_item(input logic k, input logic [RAW_W-1:0] x,
                           input logic [RAW_W-1:0] y, input logic [RAW_W-1:0] z,
                           input logic typed, input gyro_result_t res);
    in_valid <= 1'b1;
    kind <= k;
    raw_x <= x;
    raw_y <= y;
    raw_z <= z;
    in_typed <= typed;
    in_typed_res <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // The full-scale register may only change while no item is in flight. The
  // first edge lets the monitor record an item accepted at the current edge.
  task automatic write_fs_select(input logic [FSSEL_W-1:0] sel);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= sel;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver side: random bursts of out_ready low.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    gyro_result_t got;
    gyro_result_t want;
    if (rst) begin
      for (int i = 0; i < AXES; i++) sum_track[i] = 0;
      count_track = '0;
      fs_sel_track = FS_SEL_250;
    end else begin
      if (out_valid && out_ready) begin
        got.rate_x = rate_x;
        got.rate_y = rate_y;
        got.rate_z = rate_z;
        got.mean_x = mean_x;
        got.mean_y = mean_y;
        got.mean_z = mean_z;
        got.count_full = count_full;
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result item with none expected:", $realtime);
            $display("  got rate %0d %0d %0d mean %0d %0d %0d full %0d",
                     got.rate_x, got.rate_y, got.rate_z,
                     got.mean_x, got.mean_y, got.mean_z, got.count_full);
          end
        end else begin
          want = results_due.pop_front();
          if (got.rate_x !== want.rate_x || got.rate_y !== want.rate_y ||
              got.rate_z !== want.rate_z || got.mean_x !== want.mean_x ||
              got.mean_y !== want.mean_y || got.mean_z !== want.mean_z ||
              got.count_full !== want.count_full) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch:", $realtime);
              $display("  expected rate %0d %0d %0d mean %0d %0d %0d full %0d",
                       want.rate_x, want.rate_y, want.rate_z,
                       want.mean_x, want.mean_y, want.mean_z, want.count_full);
              $display("  got      rate %0d %0d %0d mean %0d %0d %0d full %0d",
                       got.rate_x, got.rate_y, got.rate_z,
                       got.mean_x, got.mean_y, got.mean_z, got.count_full);
            end
          end
        end
      end
      if (cfg_we) fs_sel_track = cfg_wdata;
      if (in_valid && in_ready) begin
        want = scale_and_average(kind, raw_x, raw_y, raw_z);
        if (in_typed) want = in_typed_res;
        results_due.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("gyro_rate_scale_and_running_mean_unit test failed");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t row;
    logic      k;
    // Directed table. The first sample after reset or a clear has a mean equal
    // to its rate, so those rows carry their result.
    plan_row(OP_ITEM, KIND_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000, FS_SEL_250, 1'b1,
             make_res(249, -250, 0, 249, -250, 0, 1'b0));
    plan_row(OP_ITEM, KIND_SAMPLE, 16'hFFFF, 16'h0001, 16'h0000, FS_SEL_250, 1'b0, '0);
    // A clear ignores its raw fields.
    plan_row(OP_ITEM, KIND_CLEAR, 16'hFFFF, 16'h8000, 16'h7FFF, FS_SEL_250, 1'b1, '0);
    plan_row(OP_ITEM, KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, FS_SEL_250, 1'b1, '0);
    plan_row(OP_CFG, KIND_SAMPLE, '0, '0, '0, FS_SEL_2000, 1'b0, '0);
    plan_row(OP_ITEM, KIND_CLEAR, 16'h1234, 16'hFEDC, 16'h0001, FS_SEL_250, 1'b1, '0);
    plan_row(OP_ITEM, KIND_SAMPLE, 16'h7FFF, 16'h8000, 16'h4000, FS_SEL_250, 1'b1,
             make_res(1999, -2000, 1000, 1999, -2000, 1000, 1'b0));
    plan_row(OP_ITEM, KIND_SAMPLE, 16'h8000, 16'h7FFF, 16'hC000, FS_SEL_250, 1'b0, '0);
    plan_row(OP_ITEM, KIND_SAMPLE, 16'hFFFF, 16'h0001, 16'h8000, FS_SEL_250, 1'b0, '0);
    plan_row(OP_CFG, KIND_SAMPLE, '0, '0, '0, FS_SEL_500, 1'b0, '0);
    plan_row(OP_ITEM, KIND_SAMPLE, 16'h5555, 16'hAAAA, 16'h7FFF, FS_SEL_250, 1'b0, '0);
    plan_row(OP_ITEM, KIND_SAMPLE, 16'hAAAA, 16'h5555, 16'h8001, FS_SEL_250, 1'b0, '0);
    plan_row(OP_CFG, KIND_SAMPLE, '0, '0, '0, FS_SEL_1000, 1'b0, '0);
    plan_row(OP_ITEM, KIND_SAMPLE, 16'h7FFF, 16'h8000, 16'hFFFF, FS_SEL_250, 1'b0, '0);
    plan_row(OP_ITEM, KIND_CLEAR, 16'h7FFF, 16'h7FFF, 16'h7FFF, FS_SEL_250, 1'b1, '0);
    plan_row(OP_ITEM, KIND_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000, FS_SEL_250, 1'b1,
             make_res(-1000, 999, 0, -1000, 999, 0, 1'b0));
    plan_row(OP_CFG, KIND_SAMPLE, '0, '0, '0, FS_SEL_250, 1'b0, '0);
    plan_row(OP_ITEM, KIND_SAMPLE, 16'h0001, 16'hFFFF, 16'h7FFF, FS_SEL_250, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < stim_plan.size(); i++) begin
      row = stim_plan[i];
      if (row.op == OP_CFG) begin
        write_fs_select(row.fs_sel);
      end else begin
        send_item(row.kind, row.x, row.y, row.z, row.typed, row.res);
      end
    end

    // Random phases; each starts by draining every result, then sets a new
    // full scale and a new amount of idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       write_fs_select(FS_SEL_2000);
        1:       write_fs_select(FS_SEL_250);
        2:       write_fs_select(FS_SEL_500);
        3:       write_fs_select(FS_SEL_1000);
        default: write_fs_select(FSSEL_W'($urandom_range(3)));
      endcase
      case ($urandom_range(3))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        2:       stall_pct = 30;
        default: stall_pct = 60;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        k = ($urandom_range(24) == 0) ? KIND_CLEAR : KIND_SAMPLE;
        send_item(k, rand_raw(), rand_raw(), rand_raw(), 1'b0, '0);
      end
    end

    // Closing run with no idling: sums pushed toward their largest magnitude
    // at the widest full scale, then a clear and a few random samples.
    stall_pct = 0;
    write_fs_select(FS_SEL_2000);
    send_item(KIND_CLEAR, rand_raw(), rand_raw(), rand_raw(), 1'b0, '0);
    for (int n = 0; n < FINAL_ITEMS; n++) begin
      send_item(KIND_SAMPLE, RAW_W'(16'h7FFF - $urandom_range(3)),
                RAW_W'(16'h8000 + $urandom_range(3)), rand_raw(), 1'b0, '0);
    end
    send_item(KIND_CLEAR, rand_raw(), rand_raw(), rand_raw(), 1'b1, '0);
    for (int n = 0; n < TAIL_ITEMS; n++)
      send_item(KIND_SAMPLE, rand_raw(), rand_raw(), rand_raw(), 1'b0, '0);
    in_valid <= 1'b0;

    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("gyro_rate_scale_and_running_mean_unit test passed");
    end else begin
      $display("gyro_rate_scale_and_running_mean_unit test failed");
    end
    $finish;
  end

endmodule

// ===== gyro_rate_scale_and_running_mean_unit.f =====
rtl/core/grsm_pkg.sv
rtl/core/grsm_ctrl.sv
rtl/core/grsm_dp.sv
rtl/core/gyro_rate_scale_and_running_mean_unit.sv
test/testbench.sv
